### hdl/sird_pkg.sv
// Shared types, constants and the radix reciprocal table for the radix digit converter.
package sird_pkg;

  localparam int unsigned SYM_W    = 8;
  localparam int unsigned NUM_SYM  = 16;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // Symbol table: symbol i sits in bits 8i+7..8i
  typedef logic [NUM_SYM-1:0][SYM_W-1:0] sym_tab_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

  // Reset contents: decimal, "0123456789"
  localparam logic [RADIX_W-1:0]    RST_BASE_LENGTH  = 5'd10;
  localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_LOW  = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  localparam logic [SYM_W-1:0]   CHAR_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0]   CHAR_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0]   SYM_MIN    = 8'd33;
  localparam logic [RADIX_W-1:0] MIN_RADIX  = 5'd2;

  // floor(2^32 / r); the quotient estimate is then low by at most one
  function automatic logic [VALUE_W-1:0] radix_recip(input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] m;
    case (r)
      5'd2:    m = 32'h8000_0000;
      5'd3:    m = 32'h5555_5555;
      5'd4:    m = 32'h4000_0000;
      5'd5:    m = 32'h3333_3333;
      5'd6:    m = 32'h2AAA_AAAA;
      5'd7:    m = 32'h2492_4924;
      5'd8:    m = 32'h2000_0000;
      5'd9:    m = 32'h1C71_C71C;
      5'd10:   m = 32'h1999_9999;
      5'd11:   m = 32'h1745_D174;
      5'd12:   m = 32'h1555_5555;
      5'd13:   m = 32'h13B1_3B13;
      5'd14:   m = 32'h1249_2492;
      5'd15:   m = 32'h1111_1111;
      5'd16:   m = 32'h1000_0000;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

### hdl/sird_table_check.sv
// Validity check of the configured symbol table (length range, forbidden and repeated symbols).
module sird_table_check #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic [sird_pkg::RADIX_W-1:0] base_length_i,
  input  sird_pkg::sym_tab_t           symbols_i,
  output logic                         table_ok_o
);
  import sird_pkg::*;

  logic bad_sym;
  logic dup_sym;

  // Every symbol in use must be no lower than SYM_MIN, not a sign, and unique
  always_comb begin
    bad_sym = 1'b0;
    dup_sym = 1'b0;
    for (int a = 0; a < MAX_BASE; a++) begin
      if (RADIX_W'(a) < base_length_i) begin
        if (symbols_i[a] == CHAR_MINUS || symbols_i[a] == CHAR_PLUS ||
            symbols_i[a] < SYM_MIN) begin
          bad_sym = 1'b1;
        end
        for (int b = a + 1; b < MAX_BASE; b++) begin
          if (RADIX_W'(b) < base_length_i && symbols_i[b] == symbols_i[a]) begin
            dup_sym = 1'b1;
          end
        end
      end
    end
  end

  assign table_ok_o = (base_length_i >= MIN_RADIX) &&
                      (base_length_i <= RADIX_W'(MAX_BASE)) &&
                      !bad_sym && !dup_sym;

endmodule

### hdl/signed_integer_to_radix_digits.sv
// Top level: signed 32-bit value to text digits in a configurable radix.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one signed value per request.
//   Output channel (out_valid_o / out_ready_i) carries one character per request,
//   last_o marking the final character of a number. Negative values start with '-'.
//   A symbol table that fails the validity check produces no characters at all.
//   The user must write configuration (cfg_we_i, cfg_index_i, cfg_wdata_i) only
//   while idle; the block itself does not enforce this.
// Operation:
//   A 32x32 multiplier by the radix reciprocal estimates each quotient, and a 32x5
//   multiply with a one-step correction yields the digit. Then the sign and each
//   digit go through the output register. in_ready_o is high only while no number
//   is being converted or emitted.
// Reset: control returns to idle, the output register empties, and the table goes
//   back to decimal "0123456789".
// Stall: while out_ready_i is low the output character holds and emission pauses;
//   the next request can be taken while the final character still waits.
module signed_integer_to_radix_digits #(
  parameter int unsigned MAX_BASE = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [sird_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sird_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  // input channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sird_pkg::VALUE_W-1:0] value_i,
  // output channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sird_pkg::SYM_W-1:0]         character_o,
  output logic                               last_o
);
  import sird_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_FIX  = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  localparam int unsigned MAX_DIGITS = VALUE_W;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = IDX_W + 1;

  // configuration registers
  logic [RADIX_W-1:0]    base_length_q;
  logic [CFG_DATA_W-1:0] symbols_low_q;
  logic [CFG_DATA_W-1:0] symbols_high_q;
  sym_tab_t              sym_tab;
  logic                  table_ok;

  state_e               state_q, state_d;
  logic                 neg_q, neg_d;
  logic [CNT_W-1:0]     nd_q, nd_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [VALUE_W-1:0]   q0_q, q0_d;
  logic [VALUE_W-1:0]   recip_q, recip_d;
  logic [RADIX_W-1:0]   radix_q, radix_d;
  logic [DIGIT_W-1:0]   digits_q [MAX_DIGITS];
  logic [DIGIT_W-1:0]   dig_rd_q;

  logic                 out_valid_q, out_valid_d;
  logic [SYM_W-1:0]     character_q, character_d;
  logic                 last_q, last_d;

  logic                 in_acc;
  logic                 load_ok;
  logic                 dig_we;
  logic                 dig_re;
  logic [DIGIT_W-1:0]   dig_wdata;
  logic [VALUE_W-1:0]   value_u;
  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W+RADIX_W-1:0] qr;
  logic [VALUE_W-1:0]   rem_full;
  logic [RADIX_W-1:0]   rem_est;
  logic [IDX_W-1:0]     rd_idx;

  assign sym_tab = {symbols_high_q, symbols_low_q};

  sird_table_check #(
    .MAX_BASE (MAX_BASE)
  ) u_table_check (
    .base_length_i (base_length_q),
    .symbols_i     (sym_tab),
    .table_ok_o    (table_ok)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_length_q  <= RST_BASE_LENGTH;
      symbols_low_q  <= RST_SYMBOLS_LOW;
      symbols_high_q <= RST_SYMBOLS_HIGH;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_LENGTH:  base_length_q  <= cfg_wdata_i[RADIX_W-1:0];
        CFG_SYMBOLS_LOW:  symbols_low_q  <= cfg_wdata_i;
        CFG_SYMBOLS_HIGH: symbols_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_ok    = !out_valid_q || out_ready_i;
  assign value_u    = value_i;

  // Shared arithmetic: quotient estimate, then remainder and one correction
  assign prod     = mag_q * recip_q;
  assign qr       = q0_q * radix_q;
  assign rem_full = mag_q - qr[VALUE_W-1:0];
  assign rem_est  = rem_full[RADIX_W-1:0];
  // digit shown after the current one
  assign rd_idx   = IDX_W'(nd_q - CNT_W'(2));

  // Sequencer
  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    nd_d        = nd_q;
    mag_d       = mag_q;
    q0_d        = q0_q;
    recip_d     = recip_q;
    radix_d     = radix_q;
    dig_we      = 1'b0;
    dig_re      = 1'b0;
    dig_wdata   = rem_est[DIGIT_W-1:0];
    out_valid_d = out_valid_q;
    character_d = character_q;
    last_d      = last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && table_ok) begin
          neg_d   = value_u[VALUE_W-1];
          mag_d   = value_u[VALUE_W-1] ? (VALUE_W'(0) - value_u) : value_u;
          nd_d    = '0;
          radix_d = base_length_q;
          recip_d = radix_recip(base_length_q);
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        q0_d    = prod[2*VALUE_W-1:VALUE_W];
        state_d = ST_FIX;
      end
      ST_FIX: begin
        dig_we = 1'b1;
        if (rem_est >= radix_q) begin
          dig_wdata = DIGIT_W'(rem_est - radix_q);
          mag_d     = q0_q + VALUE_W'(1);
        end else begin
          dig_wdata = rem_est[DIGIT_W-1:0];
          mag_d     = q0_q;
        end
        nd_d = nd_q + CNT_W'(1);
        if (mag_d == '0 || nd_q == CNT_W'(MAX_DIGITS - 1)) begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          character_d = CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_d = 1'b1;
          character_d = sym_tab[dig_rd_q];
          last_d      = (nd_q == CNT_W'(1));
          dig_re      = (nd_q != CNT_W'(1));
          nd_d        = nd_q - CNT_W'(1);
          if (nd_q == CNT_W'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      neg_q       <= 1'b0;
      nd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      nd_q        <= nd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    q0_q        <= q0_d;
    recip_q     <= recip_d;
    radix_q     <= radix_d;
    character_q <= character_d;
    last_q      <= last_d;
  end

  // Digit stack, least significant written first; dig_rd_q holds the next digit
  // to show: the newest digit after a write, else a registered read
  always_ff @(posedge clk_i) begin
    if (dig_we) begin
      digits_q[nd_q[IDX_W-1:0]] <= dig_wdata;
      dig_rd_q                  <= dig_wdata;
    end else if (dig_re) begin
      dig_rd_q <= digits_q[rd_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = character_q;
  assign last_o      = last_q;

endmodule

### hdl/sird_checker.sv
// Port-level checks on the radix digit converter, bound to the top level.
module sird_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [sird_pkg::SYM_W-1:0]  character_o,
  input logic                        last_o
);
  import sird_pkg::*;

  // A stalled character holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o))
    else $error("output character changed while stalled");

  // While a number is only partly shown, no new request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input ready in the middle of a number");

  // A non-final character is followed at once by the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("gap inside a number");

  // A minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> character_o != CHAR_MINUS)
    else $error("sign flagged as final character");

endmodule

bind signed_integer_to_radix_digits sird_checker u_sird_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .character_o (character_o),
  .last_o      (last_o)
);

### dv/signed_integer_to_radix_digits_tb.sv
// Testbench for the signed integer to radix digits converter.
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_tb;
  import sird_pkg::*;

  localparam int unsigned MAX_BASE       = 16;
  localparam int unsigned DRAIN_CYCLES   = 150;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned MAX_LOGGED     = 50;

  // write index that maps to no register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  localparam sym_tab_t DECIMAL_TAB = {RST_SYMBOLS_HIGH, RST_SYMBOLS_LOW};
  // all sixteen slots used, bytes near the forbidden ones and above 127
  localparam sym_tab_t WIDE_TAB    = {64'hFFFE_7F43_4241_3938, 64'h8021_2C2E_3332_3130};

  typedef struct packed {
    logic [SYM_W-1:0] character;
    logic             last;
  } char_item_t;

  typedef enum int unsigned {FAULT_SIGN, FAULT_CONTROL, FAULT_REPEAT} table_fault_e;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [CFG_IDX_W-1:0]       cfg_index_i;
  logic [CFG_DATA_W-1:0]      cfg_wdata_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic signed [VALUE_W-1:0]  value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [SYM_W-1:0]           character_o;
  logic                       last_o;

  // shadow copy of the configuration registers
  logic [RADIX_W-1:0]    cfg_radix    = RST_BASE_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_sym_low  = RST_SYMBOLS_LOW;
  logic [CFG_DATA_W-1:0] cfg_sym_high = RST_SYMBOLS_HIGH;

  logic signed [VALUE_W-1:0] values_to_send [$];
  char_item_t                expected_chars [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  bit          in_taken      = 1'b0;

  signed_integer_to_radix_digits #(
    .MAX_BASE(MAX_BASE)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .character_o(character_o),
    .last_o     (last_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic logic [SYM_W-1:0] sym_of(input int unsigned i);
    if (i < 8) return cfg_sym_low[8*i +: 8];
    return cfg_sym_high[8*(i-8) +: 8];
  endfunction

  function automatic bit table_valid();
    logic [SYM_W-1:0] s;
    if (cfg_radix < MIN_RADIX || cfg_radix > MAX_BASE) return 1'b0;
    for (int i = 0; i < cfg_radix; i++) begin
      s = sym_of(i);
      if (s == CHAR_PLUS || s == CHAR_MINUS || s < SYM_MIN) return 1'b0;
      for (int j = i + 1; j < cfg_radix; j++)
        if (sym_of(j) == s) return 1'b0;
    end
    return 1'b1;
  endfunction

  // queue the characters one request turns into
  function automatic void predict_text(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [DIGIT_W-1:0] digit_buf [32];
    int                 nd;
    if (!table_valid()) return;
    // magnitude in 32-bit unsigned arithmetic, so the most negative value works
    mag = v[VALUE_W-1] ? (32'd0 - v) : v;
    nd  = 0;
    do begin
      digit_buf[nd] = DIGIT_W'(mag % cfg_radix);
      nd++;
      mag = mag / cfg_radix;
    end while (mag != 0 && nd < 32);
    if (v[VALUE_W-1]) expected_chars.push_back('{CHAR_MINUS, 1'b0});
    for (int k = nd - 1; k >= 0; k--)
      expected_chars.push_back('{sym_of(digit_buf[k]), k == 0});
  endfunction

  // ---------------------------------------------------------------- drivers

  // request feeder: a new value only once the last one is taken
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (values_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        value_i    <= values_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- monitor and check

  task automatic log_error(input string msg);
    if (error_count < MAX_LOGGED) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk_i) begin : char_check
    char_item_t want;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) predict_text(value_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_chars.size() == 0) begin
        log_error($sformatf("character %h with none expected", character_o));
      end else begin
        want = expected_chars.pop_front();
        if (character_o !== want.character)
          log_error($sformatf("character %h, expected %h", character_o, want.character));
        if (last_o !== want.last)
          log_error($sformatf("last %b on %h, expected %b", last_o, character_o, want.last));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[signed_integer_to_radix_digits] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------- shared tasks

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    values_to_send.push_back(v);
  endtask

  // everything sent and emitted, then room for a conversion with no output
  task automatic wait_idle();
    while (values_to_send.size() != 0 || in_valid_i || expected_chars.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_BASE_LENGTH:  cfg_radix    = data[RADIX_W-1:0];
      CFG_SYMBOLS_LOW:  cfg_sym_low  = data;
      CFG_SYMBOLS_HIGH: cfg_sym_high = data;
      default: ;
    endcase
  endtask

  // radix goes out with random upper bits, which the block must drop
  task automatic apply_table(input int unsigned radix, input sym_tab_t tab);
    logic [CFG_DATA_W-1:0] word;
    wait_idle();
    word = {$urandom(), $urandom()};
    word[RADIX_W-1:0] = radix[RADIX_W-1:0];
    write_reg(CFG_BASE_LENGTH, word);
    write_reg(CFG_SYMBOLS_LOW, tab[7:0]);
    write_reg(CFG_SYMBOLS_HIGH, tab[15:8]);
  endtask

  // distinct legal symbols in use, random bytes above; optionally one defect
  function automatic sym_tab_t random_table(input int unsigned radix, input bit faulty);
    sym_tab_t         tab;
    bit               taken [256];
    logic [SYM_W-1:0] b;
    int unsigned      j;
    int unsigned      k;
    table_fault_e     fault;
    for (int i = 0; i < NUM_SYM; i++) begin
      if (i < radix) begin
        do b = SYM_W'($urandom_range(SYM_MIN, 255));
        while (b == CHAR_PLUS || b == CHAR_MINUS || taken[b]);
        taken[b] = 1'b1;
        tab[i]   = b;
      end else begin
        tab[i] = SYM_W'($urandom());
      end
    end
    if (faulty) begin
      j     = $urandom_range(0, radix - 1);
      fault = table_fault_e'($urandom_range(0, 2));
      case (fault)
        FAULT_SIGN:    tab[j] = $urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS;
        FAULT_CONTROL: tab[j] = SYM_W'($urandom_range(0, SYM_MIN - 1));
        default: begin
          k      = (j + $urandom_range(1, radix - 1)) % radix;
          tab[j] = tab[k];
        end
      endcase
    end
    return tab;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value(input int unsigned radix);
    logic signed [VALUE_W-1:0] v;
    longint                    p;
    int unsigned               r;
    int unsigned               k;
    r = (radix < 2 || radix > MAX_BASE) ? 10 : radix;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 3 * r);
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = 0;
          default: v = 1;
        endcase
      end
      3: begin
        // around a power of the radix, where the digit count changes
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * r <= 64'sh8000_0000) begin
          p = p * r;
          k--;
        end
        v = VALUE_W'(p - $urandom_range(0, 1));
      end
      default: v = $urandom() >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // ---------------------------------------------------------------- tests

  // decimal table straight out of reset
  task automatic test_decimal_extremes();
    send_value(0);
    send_value(7);
    send_value(-1);
    send_value(10);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh8000_0001);
    send_value(-1000000000);
    wait_idle();
  endtask

  task automatic test_radix_extremes();
    // binary: longest outputs
    apply_table(2, DECIMAL_TAB);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh5555_5555);
    send_value(0);
    // hexadecimal with every slot in use
    apply_table(16, WIDE_TAB);
    send_value(32'sh8000_0000);
    send_value(-1);
    send_value(32'sh7EDC_BA98);
    // base three, radix written with all upper bits set
    wait_idle();
    write_reg(CFG_BASE_LENGTH, 64'hFFFF_FFFF_FFFF_FFE3);
    send_value(32'sh8000_0000);
    wait_idle();
  endtask

  task automatic test_invalid_tables();
    sym_tab_t tab;
    // radix out of range
    apply_table(0, DECIMAL_TAB);
    send_value(-5);
    apply_table(1, DECIMAL_TAB);
    send_value(5);
    apply_table(MAX_BASE + 1, WIDE_TAB);
    send_value(-5);
    apply_table(31, WIDE_TAB);
    send_value(5);
    // plus sign as the last symbol in use
    tab    = DECIMAL_TAB;
    tab[9] = CHAR_PLUS;
    apply_table(10, tab);
    send_value(-123);
    // minus sign as digit zero
    tab    = DECIMAL_TAB;
    tab[0] = CHAR_MINUS;
    apply_table(10, tab);
    send_value(123);
    // space, just below the lowest legal byte
    tab    = DECIMAL_TAB;
    tab[3] = SYM_MIN - 8'd1;
    apply_table(10, tab);
    send_value(-77);
    // repeated symbol at both ends
    tab    = DECIMAL_TAB;
    tab[9] = tab[0];
    apply_table(10, tab);
    send_value(77);
    // a bad byte beyond the radix does not matter
    tab     = DECIMAL_TAB;
    tab[10] = CHAR_PLUS;
    apply_table(10, tab);
    send_value(-90210);
    // write to the spare index leaves the table alone
    wait_idle();
    write_reg(CFG_SPARE_INDEX, {$urandom(), $urandom()});
    send_value(4096);
    wait_idle();
  endtask

  task automatic test_random(input int unsigned n);
    int unsigned sent;
    int unsigned pick;
    int unsigned radix;
    int unsigned batch;
    sym_tab_t    tab;
    sent = 0;
    while (sent < n) begin
      pick = (sent == 0) ? 9 : $urandom_range(0, 9);
      case (pick)
        0: begin
          radix = $urandom_range(0, 1) ? $urandom_range(0, 1) : $urandom_range(MAX_BASE + 1, 31);
          tab   = random_table(MAX_BASE, 1'b0);
        end
        1: begin
          radix = $urandom_range(2, MAX_BASE);
          tab   = random_table(radix, 1'b1);
        end
        2: begin
          radix = 2;
          tab   = random_table(radix, 1'b0);
        end
        3: begin
          radix = MAX_BASE;
          tab   = random_table(radix, 1'b0);
        end
        default: begin
          radix = $urandom_range(2, MAX_BASE);
          tab   = random_table(radix, 1'b0);
        end
      endcase
      apply_table(radix, tab);
      batch = table_valid() ? $urandom_range(8, 30) : $urandom_range(2, 4);
      // stop at the requested count
      if (table_valid() && batch > n - sent) batch = n - sent;
      repeat (batch) begin
        send_value(random_value(radix));
        if (table_valid()) sent++;
      end
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = CFG_BASE_LENGTH;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    out_ready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 28;
    recv_idle_pct = 66;
    test_decimal_extremes();
    test_radix_extremes();
    test_invalid_tables();
    test_random(105);

    send_idle_pct = 66;
    recv_idle_pct = 28;
    test_random(105);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(105);

    wait_idle();
    if (error_count == 0) begin
      $display("[signed_integer_to_radix_digits] OK");
    end else begin
      $display("[signed_integer_to_radix_digits] ERROR");
    end
    $finish;
  end

endmodule
